>>> rtl/core/ibqm_pkg.sv
// shared types and constants of the inverse bilinear quad mapper
package ibqm_pkg;

	// saturation limit of coefficients, jacobian entries and residual terms
	localparam int VAL_LIM = 1073741823;

	// width of the signed cramer numerators and determinant
	localparam int NUM_W = 62;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// reset values of the configuration registers
	localparam logic [19:0] LEN_CSI_RST = 20'd300000;
	localparam logic [19:0] LEN_ETA_RST = 20'd600000;
	localparam logic [24:0] TOL_RST     = 25'd16777;
	localparam logic [6:0]  MAX_IT_RST  = 7'd32;
	localparam logic [6:0]  MAX_IT_CAP  = 7'd64;

	typedef enum logic [2:0] {
		REG_CORNER_ONE,
		REG_CORNER_TWO,
		REG_CORNER_THREE,
		REG_CORNER_FOUR,
		REG_LENGTH_CSI,
		REG_LENGTH_ETA,
		REG_TOLERANCE,
		REG_MAX_ITERATIONS
	} cfg_reg_t;

	// result scaling of the shared multiplier
	typedef enum logic [1:0] {
		MUL_RAW,
		MUL_TRUNC,
		MUL_ROUND
	} mul_mode_t;

	typedef struct packed {
		logic      start;
		mul_mode_t mode;
	} mul_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COEF,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DIV_GO0,
		ST_DIV_WAIT0,
		ST_DIV_GO1,
		ST_DIV_WAIT1,
		ST_UPDATE,
		ST_OUT
	} seq_state_t;

	// multiply steps of one newton iteration, then the two metre scalings
	typedef enum logic [4:0] {
		MOP_XY,
		MOP_M00,
		MOP_M01,
		MOP_M10,
		MOP_M11,
		MOP_F0A,
		MOP_F0B,
		MOP_F0C,
		MOP_F1A,
		MOP_F1B,
		MOP_F1C,
		MOP_DETA,
		MOP_DETB,
		MOP_N0A,
		MOP_N0B,
		MOP_N1A,
		MOP_N1B,
		MOP_CSI,
		MOP_ETA
	} mop_t;

endpackage

>>> rtl/core/ibqm_mul.sv
// multi-cycle signed multiplier, 16 bits of one operand per cycle
module ibqm_mul #(
	parameter int FRAC_BITS = 30,
	parameter int MAG_W     = 37
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ibqm_pkg::mul_ctl_t     ctl,
	input  logic signed [MAG_W:0]  a,
	input  logic signed [MAG_W:0]  b,
	output logic                   done,
	output logic signed [2*MAG_W:0] p
);
	import ibqm_pkg::*;

	localparam int K  = (MAG_W + 15) / 16;
	localparam int BW = 16 * K;
	localparam int PW = MAG_W + BW;
	localparam int RW = 2 * MAG_W + 1;
	localparam int CW = (K > 1) ? $clog2(K) : 1;

	logic [MAG_W-1:0]    amag_q;
	logic [BW-1:0]       bsh_q;
	logic [PW-1:0]       acc_q;
	logic                neg_q;
	mul_mode_t           mode_q;
	logic [CW-1:0]       cnt_q;
	logic                run_q;
	logic                fin_q;
	logic                done_q;
	logic signed [RW-1:0] p_q;

	logic [MAG_W:0]      a_abs;
	logic [MAG_W:0]      b_abs;
	logic [MAG_W+15:0]   part;
	logic [PW-1:0]       acc_nx;
	logic [RW-1:0]       mag;
	logic [RW-1:0]       m;
	logic signed [RW-1:0] p_nx;

	assign a_abs  = a[MAG_W] ? (MAG_W+1)'(-a) : (MAG_W+1)'(a);
	assign b_abs  = b[MAG_W] ? (MAG_W+1)'(-b) : (MAG_W+1)'(b);
	assign part   = amag_q * bsh_q[BW-1 -: 16];
	assign acc_nx = {acc_q[PW-17:0], 16'h0000} + PW'(part);
	assign mag    = RW'(acc_q[2*MAG_W-1:0]);

	always_comb begin
		case (mode_q)
			MUL_RAW:   m = mag;
			MUL_TRUNC: m = mag >> FRAC_BITS;
			MUL_ROUND: m = (mag + (RW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
			default:   m = mag;
		endcase
		p_nx = neg_q ? -$signed(m) : $signed(m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(K - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			amag_q <= a_abs[MAG_W-1:0];
			bsh_q  <= BW'(b_abs[MAG_W-1:0]);
			acc_q  <= '0;
			neg_q  <= a[MAG_W] ^ b[MAG_W];
			mode_q <= ctl.mode;
		end else if (run_q) begin
			acc_q <= acc_nx;
			bsh_q <= bsh_q << 16;
		end
		if (fin_q) begin
			p_q <= p_nx;
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

>>> rtl/core/ibqm_div.sv
// restoring divider for the newton step, quotient with fraction bits
module ibqm_div #(
	parameter int FRAC_BITS = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ibqm_pkg::NUM_W-1:0] num,
	input  logic signed [ibqm_pkg::NUM_W-1:0] den,
	output logic                              done,
	output logic signed [FRAC_BITS+5:0]       step
);
	import ibqm_pkg::*;

	localparam int QW  = FRAC_BITS + 4;
	localparam int SOW = FRAC_BITS + 6;
	localparam int DM  = NUM_W;
	localparam int CW  = $clog2(QW);
	localparam logic signed [SOW-1:0] STEP_LIM = {2'b01, {QW{1'b0}}};

	logic [DM:0]          r_q;
	logic [DM+2:0]        dd_q;
	logic [DM-1:0]        d_q;
	logic [QW-1:0]        q_q;
	logic [CW-1:0]        cnt_q;
	logic                 neg_q;
	logic                 chk_q;
	logic                 run_q;
	logic                 fin_q;
	logic                 done_q;
	logic signed [SOW-1:0] step_q;

	logic [DM-1:0]        n_abs;
	logic [DM-1:0]        d_abs;
	logic                 big;
	logic                 phase2;
	logic [DM:0]          tr;
	logic                 ge;
	logic [DM:0]          sub;
	logic signed [SOW-1:0] qs;

	assign n_abs  = num[DM-1] ? DM'(-num) : DM'(num);
	assign d_abs  = den[DM-1] ? DM'(-den) : DM'(den);
	// quotient of 16 or more saturates
	assign big    = (DM+4)'(r_q) >= {d_q, 4'b0000};
	assign phase2 = cnt_q >= CW'(4);
	assign tr     = phase2 ? {r_q[DM-1:0], 1'b0} : r_q;
	assign ge     = (DM+3)'(tr) >= dd_q;
	assign sub    = tr - dd_q[DM:0];
	assign qs     = $signed({2'b00, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					chk_q <= 1'b1;
				end
			end
			if (chk_q) begin
				chk_q <= 1'b0;
				if (big) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= '0;
				end
			end
			if (run_q) begin
				if (cnt_q == CW'(QW - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= {1'b0, n_abs};
			d_q    <= d_abs;
			neg_q  <= (num[DM-1] == den[DM-1]);
			step_q <= '0;
		end
		if (chk_q) begin
			dd_q <= {d_q, 3'b000};
			if (big) begin
				step_q <= neg_q ? -STEP_LIM : STEP_LIM;
			end
		end
		if (run_q) begin
			r_q <= ge ? sub : tr;
			q_q <= {q_q[QW-2:0], ge};
			if (cnt_q < CW'(3)) begin
				dd_q <= dd_q >> 1;
			end
		end
		if (fin_q) begin
			step_q <= neg_q ? -qs : qs;
		end
	end

	assign done = done_q;
	assign step = step_q;

endmodule

>>> rtl/core/inverse_bilinear_quad_mapper_top.sv
// inverse bilinear quad mapper: sequencer, registers and shared units
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  point    | point_valid / point_stall  | point_lon, point_lat
//  result   | result_valid / result_stall| csi_metres, eta_metres, converged,
//           |                            | iterations_used
//  config   | cfg_we                     | cfg_index, cfg_data
//
// one request at a time; each newton iteration runs 17 multiplies on the shared
// chunked multiplier and two divides on the divider, and two more multiplies
// scale the final iterate to metres
// point_stall is high from accept until the result is taken
// the result is held in registers while result_stall is high
// asynchronous active-low reset returns the sequencer to idle and the
// configuration registers to their reset values
module inverse_bilinear_quad_mapper_top #(
	parameter int ITER_FRAC_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ibqm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ibqm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 point_valid,
	output logic                                 point_stall,
	input  logic signed [31:0]                   point_lon,
	input  logic signed [31:0]                   point_lat,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [23:0]                   csi_metres,
	output logic signed [23:0]                   eta_metres,
	output logic                                 converged,
	output logic [6:0]                           iterations_used
);
	import ibqm_pkg::*;

	localparam int F   = ITER_FRAC_BITS;
	// magnitude width of multiplier operands
	localparam int MW  = (F + 7 > 31) ? F + 7 : 31;
	localparam int AW  = MW + 1;
	localparam int RW  = 2 * MW + 1;
	localparam int XW  = F + 5;
	localparam int XYW = F + 8;
	localparam int SOW = F + 6;
	localparam int UW  = F + 7;
	localparam int VW  = 31;
	localparam int EW  = 36;

	localparam logic signed [RW-1:0] VLIM_W = RW'(VAL_LIM);
	localparam logic signed [VW-1:0] VLIM_P = VW'(VAL_LIM);
	localparam logic signed [VW-1:0] VLIM_N = -VW'(VAL_LIM);
	localparam logic signed [UW-1:0] XLIM_P = UW'(1) <<< (F + 3);
	localparam logic signed [UW-1:0] XLIM_N = -(UW'(1) <<< (F + 3));
	localparam logic signed [AW-1:0] ONE_A  = AW'(1) <<< F;
	localparam logic signed [RW-1:0] MET_P  = RW'(8388607);
	localparam logic signed [RW-1:0] MET_N  = -RW'(8388608);

	// saturate to the coefficient range
	function automatic logic signed [VW-1:0] sat_val(input logic signed [RW-1:0] v);
		if (v > VLIM_W) begin
			return VLIM_P;
		end else if (v < -VLIM_W) begin
			return VLIM_N;
		end
		return v[VW-1:0];
	endfunction

	// keep the iterate within +-8.0
	function automatic logic signed [XW-1:0] sat_x(input logic signed [UW-1:0] v);
		if (v > XLIM_P) begin
			return XLIM_P[XW-1:0];
		end else if (v < XLIM_N) begin
			return XLIM_N[XW-1:0];
		end
		return v[XW-1:0];
	endfunction

	function automatic logic signed [23:0] clamp_m(input logic signed [RW-1:0] v);
		if (v > MET_P) begin
			return MET_P[23:0];
		end else if (v < MET_N) begin
			return MET_N[23:0];
		end
		return v[23:0];
	endfunction

	// configuration registers
	logic [CFG_DATA_W-1:0] corner_q [4];
	logic [19:0]           len_csi_q;
	logic [19:0]           len_eta_q;
	logic [24:0]           tol_q;
	logic [6:0]            max_it_q;

	// sequencer
	seq_state_t state_q;
	seq_state_t state_nx;
	mop_t       mop_q;
	logic [6:0] it_q;
	logic       conv_q;

	// datapath registers
	logic signed [31:0]     pt_lat_q;
	logic signed [31:0]     pt_lon_q;
	logic signed [VW-1:0]   ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic signed [XYW-1:0]  xy_q;
	logic signed [VW-1:0]   m00_q, m01_q, m10_q, m11_q, f0_q, f1_q;
	logic signed [RW-1:0]   acc_q;
	logic signed [NUM_W-1:0] det_q, n0_q, n1_q;
	logic signed [SOW-1:0]  s0_q, s1_q;
	logic signed [23:0]     csi_q, eta_q;

	// shared units
	mul_ctl_t               mul_ctl;
	logic                   mul_go;
	mul_mode_t              mul_mode;
	logic signed [AW-1:0]   mul_a, mul_b;
	logic                   mul_done;
	logic signed [RW-1:0]   mul_p;
	logic                   div_go;
	logic signed [NUM_W-1:0] div_num;
	logic                   div_done;
	logic signed [SOW-1:0]  div_step;

	// combinational helpers
	logic signed [EW-1:0]   lat_e [4];
	logic signed [EW-1:0]   lon_e [4];
	logic signed [EW-1:0]   px_e, py_e;
	logic signed [RW-1:0]   acc_sum, acc_dif;
	logic [VW-1:0]          af0, af1;
	logic [31:0]            res;
	logic                   hit;
	logic [6:0]             cap;
	logic [6:0]             it_nx;
	logic                   finish;

	// configuration writes, taken at every edge with cfg_we high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				corner_q[i] <= '0;
			end
			len_csi_q <= LEN_CSI_RST;
			len_eta_q <= LEN_ETA_RST;
			tol_q     <= TOL_RST;
			max_it_q  <= MAX_IT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CORNER_ONE:     corner_q[0] <= cfg_data;
				REG_CORNER_TWO:     corner_q[1] <= cfg_data;
				REG_CORNER_THREE:   corner_q[2] <= cfg_data;
				REG_CORNER_FOUR:    corner_q[3] <= cfg_data;
				REG_LENGTH_CSI:     len_csi_q   <= cfg_data[19:0];
				REG_LENGTH_ETA:     len_eta_q   <= cfg_data[19:0];
				REG_TOLERANCE:      tol_q       <= cfg_data[24:0];
				REG_MAX_ITERATIONS: max_it_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// bilinear coefficients; x pairs with latitude, y with longitude
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lat_e[i] = EW'($signed(corner_q[i][63:32]));
			lon_e[i] = EW'($signed(corner_q[i][31:0]));
		end
		px_e = EW'(pt_lat_q);
		py_e = EW'(pt_lon_q);
	end

	// iteration cap clamped to 1..64
	always_comb begin
		if (max_it_q == '0) begin
			cap = 7'd1;
		end else if (max_it_q > MAX_IT_CAP) begin
			cap = MAX_IT_CAP;
		end else begin
			cap = max_it_q;
		end
	end

	// l1 residual measured before the update
	assign af0     = f0_q[VW-1] ? VW'(-f0_q) : VW'(f0_q);
	assign af1     = f1_q[VW-1] ? VW'(-f1_q) : VW'(f1_q);
	assign res     = {1'b0, af0} + {1'b0, af1};
	assign hit     = res <= 32'(tol_q);
	assign it_nx   = it_q + 7'd1;
	assign finish  = hit || (it_nx >= cap);
	assign acc_sum = acc_q + mul_p;
	assign acc_dif = acc_q - mul_p;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					state_nx = ST_COEF;
				end
			end
			ST_COEF:   state_nx = ST_MUL_GO;
			ST_MUL_GO: state_nx = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (mul_done) begin
					if (mop_q == MOP_N1B) begin
						state_nx = ST_DIV_GO0;
					end else if (mop_q == MOP_ETA) begin
						state_nx = ST_OUT;
					end else begin
						state_nx = ST_MUL_GO;
					end
				end
			end
			ST_DIV_GO0: state_nx = ST_DIV_WAIT0;
			ST_DIV_WAIT0: begin
				if (div_done) begin
					state_nx = ST_DIV_GO1;
				end
			end
			ST_DIV_GO1: state_nx = ST_DIV_WAIT1;
			ST_DIV_WAIT1: begin
				if (div_done) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: state_nx = ST_MUL_GO;
			ST_OUT: begin
				if (!result_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		point_stall  = (state_q != ST_IDLE);
		result_valid = (state_q == ST_OUT);
		mul_go       = (state_q == ST_MUL_GO);
		div_go       = (state_q == ST_DIV_GO0) || (state_q == ST_DIV_GO1);
		div_num      = (state_q == ST_DIV_GO1) ? n1_q : n0_q;
	end

	// multiplier operand selection per step
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_mode = MUL_TRUNC;
		case (mop_q)
			MOP_XY: begin
				mul_a = AW'(x_q);
				mul_b = AW'(y_q);
			end
			MOP_M00: begin
				mul_a = AW'(dx_q);
				mul_b = AW'(y_q);
			end
			MOP_M01: begin
				mul_a = AW'(dx_q);
				mul_b = AW'(x_q);
			end
			MOP_M10: begin
				mul_a = AW'(dy_q);
				mul_b = AW'(y_q);
			end
			MOP_M11: begin
				mul_a = AW'(dy_q);
				mul_b = AW'(x_q);
			end
			MOP_F0A: begin
				mul_a = AW'(bx_q);
				mul_b = AW'(x_q);
			end
			MOP_F0B: begin
				mul_a = AW'(cx_q);
				mul_b = AW'(y_q);
			end
			MOP_F0C: begin
				mul_a = AW'(dx_q);
				mul_b = AW'(xy_q);
			end
			MOP_F1A: begin
				mul_a = AW'(by_q);
				mul_b = AW'(x_q);
			end
			MOP_F1B: begin
				mul_a = AW'(cy_q);
				mul_b = AW'(y_q);
			end
			MOP_F1C: begin
				mul_a = AW'(dy_q);
				mul_b = AW'(xy_q);
			end
			MOP_DETA: begin
				mul_a    = AW'(m00_q);
				mul_b    = AW'(m11_q);
				mul_mode = MUL_RAW;
			end
			MOP_DETB: begin
				mul_a    = AW'(m10_q);
				mul_b    = AW'(m01_q);
				mul_mode = MUL_RAW;
			end
			MOP_N0A: begin
				mul_a    = AW'(f0_q);
				mul_b    = AW'(m11_q);
				mul_mode = MUL_RAW;
			end
			MOP_N0B: begin
				mul_a    = AW'(f1_q);
				mul_b    = AW'(m01_q);
				mul_mode = MUL_RAW;
			end
			MOP_N1A: begin
				mul_a    = AW'(f1_q);
				mul_b    = AW'(m00_q);
				mul_mode = MUL_RAW;
			end
			MOP_N1B: begin
				mul_a    = AW'(f0_q);
				mul_b    = AW'(m10_q);
				mul_mode = MUL_RAW;
			end
			// metres: 0.5*(t+1)*length, rounded half away from zero
			MOP_CSI: begin
				mul_a    = AW'(x_q) + ONE_A;
				mul_b    = AW'({1'b0, len_csi_q});
				mul_mode = MUL_ROUND;
			end
			MOP_ETA: begin
				mul_a    = AW'(y_q) + ONE_A;
				mul_b    = AW'({1'b0, len_eta_q});
				mul_mode = MUL_ROUND;
			end
			default: begin
				mul_a    = '0;
				mul_b    = '0;
				mul_mode = MUL_RAW;
			end
		endcase
	end

	assign mul_ctl = '{start: mul_go, mode: mul_mode};

	ibqm_mul #(
		.FRAC_BITS (F),
		.MAG_W     (MW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	ibqm_div #(
		.FRAC_BITS (F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.step   (div_step)
	);

	// sequencer state, step index, iteration count and convergence flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mop_q   <= MOP_XY;
			it_q    <= '0;
			conv_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_IDLE: begin
					if (point_valid) begin
						it_q   <= '0;
						conv_q <= 1'b0;
					end
				end
				ST_COEF: mop_q <= MOP_XY;
				ST_MUL_WAIT: begin
					if (mul_done && mop_q != MOP_N1B && mop_q != MOP_ETA) begin
						mop_q <= mop_t'(mop_q + 5'd1);
					end
				end
				ST_UPDATE: begin
					it_q   <= it_nx;
					conv_q <= hit;
					mop_q  <= finish ? MOP_CSI : MOP_XY;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					pt_lat_q <= point_lat;
					pt_lon_q <= point_lon;
					x_q      <= '0;
					y_q      <= '0;
				end
			end
			ST_COEF: begin
				ax_q <= sat_val(RW'((px_e <<< 2) - (lat_e[0] + lat_e[1] + lat_e[2] + lat_e[3])));
				ay_q <= sat_val(RW'((py_e <<< 2) - (lon_e[0] + lon_e[1] + lon_e[2] + lon_e[3])));
				bx_q <= sat_val(RW'(-lat_e[0] + lat_e[1] + lat_e[2] - lat_e[3]));
				by_q <= sat_val(RW'(-lon_e[0] + lon_e[1] + lon_e[2] - lon_e[3]));
				cx_q <= sat_val(RW'(-lat_e[0] - lat_e[1] + lat_e[2] + lat_e[3]));
				cy_q <= sat_val(RW'(-lon_e[0] - lon_e[1] + lon_e[2] + lon_e[3]));
				dx_q <= sat_val(RW'(lat_e[0] - lat_e[1] + lat_e[2] - lat_e[3]));
				dy_q <= sat_val(RW'(lon_e[0] - lon_e[1] + lon_e[2] - lon_e[3]));
			end
			ST_MUL_WAIT: begin
				if (mul_done) begin
					case (mop_q)
						MOP_XY:   xy_q  <= mul_p[XYW-1:0];
						MOP_M00:  m00_q <= sat_val(RW'(bx_q) + mul_p);
						MOP_M01:  m01_q <= sat_val(RW'(cx_q) + mul_p);
						MOP_M10:  m10_q <= sat_val(RW'(by_q) + mul_p);
						MOP_M11:  m11_q <= sat_val(RW'(cy_q) + mul_p);
						MOP_F0A:  acc_q <= mul_p - RW'(ax_q);
						MOP_F0B:  acc_q <= acc_sum;
						MOP_F0C:  f0_q  <= sat_val(acc_sum);
						MOP_F1A:  acc_q <= mul_p - RW'(ay_q);
						MOP_F1B:  acc_q <= acc_sum;
						MOP_F1C:  f1_q  <= sat_val(acc_sum);
						MOP_DETA: acc_q <= mul_p;
						MOP_DETB: det_q <= acc_dif[NUM_W-1:0];
						MOP_N0A:  acc_q <= mul_p;
						MOP_N0B:  n0_q  <= acc_dif[NUM_W-1:0];
						MOP_N1A:  acc_q <= mul_p;
						MOP_N1B:  n1_q  <= acc_dif[NUM_W-1:0];
						MOP_CSI:  csi_q <= clamp_m(mul_p);
						MOP_ETA:  eta_q <= clamp_m(mul_p);
						default: ;
					endcase
				end
			end
			ST_DIV_WAIT0: begin
				if (div_done) begin
					s0_q <= div_step;
				end
			end
			ST_DIV_WAIT1: begin
				if (div_done) begin
					s1_q <= div_step;
				end
			end
			ST_UPDATE: begin
				x_q <= sat_x(UW'(x_q) + UW'(s0_q));
				y_q <= sat_x(UW'(y_q) + UW'(s1_q));
			end
			default: ;
		endcase
	end

	assign csi_metres      = csi_q;
	assign eta_metres      = eta_q;
	assign converged       = conv_q;
	assign iterations_used = it_q;

`ifndef SYNTHESIS
	// the multiplier reports only to a sequencer that waits for it
	a_mul_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL_WAIT)
		else $error("multiplier result arrived outside a multiply wait");

	a_div_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT0 || state_q == ST_DIV_WAIT1))
		else $error("divider result arrived outside a divide wait");

	// a reported result ran at least one and at most cap iterations
	a_iter_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (iterations_used != 7'd0 && iterations_used <= cap))
		else $error("iteration count outside the cap");

	// without convergence the cap must have been hit
	a_cap_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !converged) |-> iterations_used == cap)
		else $error("stopped early without convergence");
`endif

endmodule
